[rtl/core/hdlcd_pkg.sv]
package hdlcd_pkg;

    localparam logic [10:0] MAX_FRAME = 11'd1024;

    typedef enum logic [1:0] {
        CFG_FLAG_BYTE   = 2'd0,
        CFG_ESCAPE_BYTE = 2'd1,
        CFG_XOR_MASK    = 2'd2,
        CFG_MAX_PAYLOAD = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_AWAIT = 2'd0,
        PH_DATA  = 2'd1,
        PH_ESC   = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        EV_IGNORED  = 4'd0,
        EV_BYTE     = 4'd1,
        EV_DONE     = 4'd2,
        EV_LINE     = 4'd3,
        EV_NOFLAG   = 4'd4,
        EV_EMPTY    = 4'd5,
        EV_OVERFLOW = 4'd6,
        EV_BADESC   = 4'd7,
        EV_ESC      = 4'd8,
        EV_OPEN     = 4'd9,
        EV_ARMED    = 4'd10
    } event_t;

    typedef struct packed {
        logic [7:0]  flag_byte;
        logic [7:0]  escape_byte;
        logic [7:0]  escape_xor_mask;
        logic [10:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
        logic       overrun_err;
        logic       framing_err;
        logic       parity_err;
    } item_t;

    typedef struct packed {
        phase_t      phase;
        logic        armed;
        logic [10:0] payload_count;
    } rx_state_t;

    typedef struct packed {
        logic [15:0] overrun;
        logic [15:0] framing;
        logic [15:0] parity;
        logic [15:0] missing_flag;
        logic [15:0] empty_frame;
        logic [15:0] overflow;
        logic [15:0] bad_escape;
    } counters_t;

endpackage

[rtl/core/hdlcd_decode.sv]
module hdlcd_decode
    import hdlcd_pkg::*;
(
    input  cfg_t        cfg,
    input  item_t       item,
    input  rx_state_t   state,
    input  counters_t   counts,
    output rx_state_t   state_next,
    output counters_t   counts_next,
    output event_t      event_res,
    output logic [7:0]  data_byte
);

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        sat_inc = (c == 16'hFFFF) ? c : c + 16'd1;
    endfunction

    logic [10:0] limit;
    logic        room;
    logic [7:0]  unescaped;

    assign limit     = (cfg.max_payload > MAX_FRAME) ? MAX_FRAME : cfg.max_payload;
    assign room      = state.payload_count < limit;
    assign unescaped = item.rx_byte ^ cfg.escape_xor_mask;

    always_comb
    begin
        state_next  = state;
        counts_next = counts;
        event_res   = EV_IGNORED;
        data_byte   = 8'd0;
        priority if (item.op)
        begin
            state_next.phase         = PH_AWAIT;
            state_next.payload_count = 11'd0;
            state_next.armed         = 1'b1;
            event_res                = EV_ARMED;
        end
        else if (!state.armed)
        begin
            event_res = EV_IGNORED;
        end
        else if (item.overrun_err || item.framing_err || item.parity_err)
        begin
            priority if (item.overrun_err)
                counts_next.overrun = sat_inc(counts.overrun);
            else if (item.framing_err)
                counts_next.framing = sat_inc(counts.framing);
            else
                counts_next.parity = sat_inc(counts.parity);
            state_next.phase = PH_AWAIT;
            event_res        = EV_LINE;
        end
        else if (state.phase == PH_DATA)
        begin
            priority if (item.rx_byte == cfg.flag_byte)
            begin
                if (state.payload_count != 11'd0)
                begin
                    state_next.armed = 1'b0;
                    event_res        = EV_DONE;
                end
                else
                begin
                    counts_next.empty_frame = sat_inc(counts.empty_frame);
                    event_res               = EV_EMPTY;
                end
            end
            else if (item.rx_byte == cfg.escape_byte)
            begin
                state_next.phase = PH_ESC;
                event_res        = EV_ESC;
            end
            else if (room)
            begin
                state_next.payload_count = state.payload_count + 11'd1;
                data_byte                = item.rx_byte;
                event_res                = EV_BYTE;
            end
            else
            begin
                counts_next.overflow = sat_inc(counts.overflow);
                state_next.phase     = PH_AWAIT;
                event_res            = EV_OVERFLOW;
            end
        end
        else if (state.phase == PH_ESC)
        begin
            priority if (!room)
            begin
                counts_next.overflow = sat_inc(counts.overflow);
                state_next.phase     = PH_AWAIT;
                event_res            = EV_OVERFLOW;
            end
            else if (unescaped == cfg.flag_byte || unescaped == cfg.escape_byte)
            begin
                state_next.payload_count = state.payload_count + 11'd1;
                state_next.phase         = PH_DATA;
                data_byte                = unescaped;
                event_res                = EV_BYTE;
            end
            else
            begin
                counts_next.bad_escape = sat_inc(counts.bad_escape);
                state_next.phase       = PH_AWAIT;
                event_res              = EV_BADESC;
            end
        end
        else
        begin
            if (item.rx_byte == cfg.flag_byte)
            begin
                state_next.phase         = PH_DATA;
                state_next.payload_count = 11'd0;
                event_res                = EV_OPEN;
            end
            else
            begin
                state_next.phase         = PH_AWAIT;
                counts_next.missing_flag = sat_inc(counts.missing_flag);
                event_res                = EV_NOFLAG;
            end
        end
    end

endmodule

[rtl/core/hdlc_byte_stuffing_deframer.sv]
// channel   direction  content
// s_*       in         tuser op, tdata rx_byte and line error flags
// m_*       out        tuser event, tdata decoded byte, length, error counters
// cfg_*     in         register writes, no read-back
//
// one beat per cycle sustained while m_tready is high; an input beat reaches the result beat via the
// input register, then decode and state update into the result register
// reset returns to disarmed, awaiting opening flag, all counters zero
// a stalled result still lets one more beat into the input register
module hdlc_byte_stuffing_deframer
    import hdlcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // rx_byte, overrun_err, framing_err, parity_err
    input  logic         s_tuser,   // op
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // data_byte, frame_length, overrun_total,
                                    // framing_total, parity_total, missing_flag_total,
                                    // empty_frame_total, overflow_total, bad_escape_total
    output logic [3:0]   m_tuser,   // event_res
    input  logic         cfg_wen,
    input  logic [1:0]   cfg_addr,
    input  logic [10:0]  cfg_wdata
);

    cfg_t       cfg_reg;
    item_t      in_item_reg;
    logic       in_valid_reg;
    rx_state_t  state_reg;
    rx_state_t  state_next;
    counters_t  counts_reg;
    counters_t  counts_next;
    logic       out_valid_reg;
    event_t     out_event_reg;
    event_t     event_next;
    logic [7:0] out_data_reg;
    logic [7:0] data_next;
    logic       advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.flag_byte       <= 8'd126;
            cfg_reg.escape_byte     <= 8'd125;
            cfg_reg.escape_xor_mask <= 8'd32;
            cfg_reg.max_payload     <= 11'd1024;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_FLAG_BYTE:   cfg_reg.flag_byte       <= cfg_wdata[7:0];
                CFG_ESCAPE_BYTE: cfg_reg.escape_byte     <= cfg_wdata[7:0];
                CFG_XOR_MASK:    cfg_reg.escape_xor_mask <= cfg_wdata[7:0];
                CFG_MAX_PAYLOAD: cfg_reg.max_payload     <= cfg_wdata;
                default:         cfg_reg.max_payload     <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.op          <= s_tuser;
            in_item_reg.rx_byte     <= s_tdata[7:0];
            in_item_reg.overrun_err <= s_tdata[8];
            in_item_reg.framing_err <= s_tdata[9];
            in_item_reg.parity_err  <= s_tdata[10];
        end
    end

    hdlcd_decode u_decode (
        .cfg         (cfg_reg),
        .item        (in_item_reg),
        .state       (state_reg),
        .counts      (counts_reg),
        .state_next  (state_next),
        .counts_next (counts_next),
        .event_res   (event_next),
        .data_byte   (data_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_AWAIT;
            state_reg.armed         <= 1'b0;
            state_reg.payload_count <= 11'd0;
            counts_reg              <= '0;
            out_valid_reg           <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || m_tready)
                out_valid_reg <= in_valid_reg;
            if (advance)
            begin
                state_reg  <= state_next;
                counts_reg <= counts_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_event_reg <= event_next;
            out_data_reg  <= data_next;
        end
    end

    // counters and length reflect the beat in the result register
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_event_reg;
    assign m_tdata  = {5'd0,
                       counts_reg.bad_escape,
                       counts_reg.overflow,
                       counts_reg.empty_frame,
                       counts_reg.missing_flag,
                       counts_reg.parity,
                       counts_reg.framing,
                       counts_reg.overrun,
                       state_reg.payload_count,
                       out_data_reg};

    a_arm_clears_length: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == EV_ARMED) |-> (m_tdata[18:8] == 11'd0))
        else $error("arm beat with nonzero frame length");

    a_byte_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == EV_BYTE) |-> (m_tdata[18:8] != 11'd0))
        else $error("payload beat with zero frame length");

    a_escape_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_ESC) |-> state_reg.armed)
        else $error("escape phase while disarmed");

    a_state_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && $past(rst_n)) |=> ($stable(state_reg) && $stable(counts_reg)))
        else $error("state changed without a result beat");

endmodule
